// ----- hdl/point_segment_distance_top_macros.svh -----
// ----------------------------------------------------------------------------
// Point to segment distance - assertion macros
// Shared concurrent assertion forms for the distance pipeline.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_TOP_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PSD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psd: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PSD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psd: next-cycle check failed");

`endif

// ----- hdl/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// Point to segment distance - package
// Default sizing for the top level, from which its pipelined units are sized.
// ----------------------------------------------------------------------------
package psd_pkg;

    // coordinate width of one signed fixed-point input
    localparam int COORD_WIDTH_DEF = 32;

endpackage

// ----- hdl/psd_div.sv -----
// ----------------------------------------------------------------------------
// Point to segment distance - pipelined divider
// Restoring division, one quotient bit per register stage.
// The high part of the numerator must already be below the divisor.
// ----------------------------------------------------------------------------
module psd_div #(
    parameter int NUMW = 132,
    parameter int DENW = 66,
    parameter int QW   = 65
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_valid,
    output logic [QW-1:0]   o_quo
);

    logic [DENW-1:0] r_rem [QW];
    logic [QW-1:0]   r_lo  [QW];
    logic [DENW-1:0] r_den [QW];
    logic [QW-1:0]   r_quo [QW];
    logic [QW-1:0]   r_vld;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DENW-1:0] c_rem;
        logic [QW-1:0]   c_lo;
        logic [DENW-1:0] c_den;
        logic [QW-1:0]   c_quo;
        logic            c_vld;
        logic [DENW:0]   c_sh;
        logic [DENW:0]   c_diff;
        logic [DENW-1:0] n_rem;
        logic [QW-1:0]   n_quo;

        // stage source: divider inputs or previous stage
        if (j == 0) begin : g_src
            assign c_rem = i_num[QW +: DENW];
            assign c_lo  = i_num[QW-1:0];
            assign c_den = i_den;
            assign c_quo = '0;
            assign c_vld = i_valid;
        end else begin : g_src
            assign c_rem = r_rem[j-1];
            assign c_lo  = r_lo[j-1];
            assign c_den = r_den[j-1];
            assign c_quo = r_quo[j-1];
            assign c_vld = r_vld[j-1];
        end

        // bring down next numerator bit, trial subtract
        assign c_sh   = {c_rem, c_lo[QW-1]};
        assign c_diff = c_sh - {1'b0, c_den};

        always_comb begin
            if (!c_diff[DENW]) begin
                n_rem = c_diff[DENW-1:0];
                n_quo = {c_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = c_sh[DENW-1:0];
                n_quo = {c_quo[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_lo[j]  <= {c_lo[QW-2:0], 1'b0};
                r_den[j] <= c_den;
                r_quo[j] <= n_quo;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];

endmodule

// ----- hdl/psd_sqrt.sv -----
// ----------------------------------------------------------------------------
// Point to segment distance - pipelined square root
// Digit-by-digit integer square root, one root bit per register stage,
// result truncated toward zero.
// ----------------------------------------------------------------------------
module psd_sqrt #(
    parameter int RW = 33
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    output logic            o_valid,
    output logic [RW-1:0]   o_root
);

    localparam int XW  = 2 * RW;
    localparam int RMW = RW + 2;

    logic [RMW-1:0] r_rem  [RW];
    logic [XW-1:0]  r_x    [RW];
    logic [RW-1:0]  r_root [RW];
    logic [RW-1:0]  r_vld;

    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic [RMW-1:0] c_rem;
        logic [XW-1:0]  c_x;
        logic [RW-1:0]  c_root;
        logic           c_vld;
        logic [RMW-1:0] c_sh;
        logic [RMW:0]   c_diff;
        logic [RMW-1:0] n_rem;
        logic [RW-1:0]  n_root;

        if (j == 0) begin : g_src
            assign c_rem  = '0;
            assign c_x    = i_rad;
            assign c_root = '0;
            assign c_vld  = i_valid;
        end else begin : g_src
            assign c_rem  = r_rem[j-1];
            assign c_x    = r_x[j-1];
            assign c_root = r_root[j-1];
            assign c_vld  = r_vld[j-1];
        end

        // next bit pair in, trial value 4*root+1
        assign c_sh   = {c_rem[RMW-3:0], c_x[XW-1 -: 2]};
        assign c_diff = {1'b0, c_sh} - {1'b0, c_root, 2'b01};

        always_comb begin
            if (!c_diff[RMW]) begin
                n_rem  = c_diff[RMW-1:0];
                n_root = {c_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = c_sh;
                n_root = {c_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_x[j]    <= {c_x[XW-3:0], 2'b00};
                r_root[j] <= n_root;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];

endmodule

// ----- hdl/point_segment_distance_top.sv -----
// ----------------------------------------------------------------------------
// Point to segment distance - top level
// Distance from a 2D point to a line segment, signed fixed-point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries segment start, segment end and
//   query point; output channel (o_valid / i_ready) returns the truncated
//   distance with the same fraction bits as the inputs, one bit wider.
//   Throughput: one transaction per cycle while the receiver takes results.
//   Depth is set by the divider (one quotient bit per stage) and the square
//   root (one root bit per stage).
//   Front end: differences, products, sums, path select, cross-product
//   square in partial products, numerator/divisor select (six stages).
//   Endpoint cases pass through the divider with a divisor of one.
//   Reset clears all stage valid bits; no transaction is in flight after it.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_ready drops; nothing is lost or repeated. Bubbles move
//   forward whenever the output stage is empty or being taken.
// ----------------------------------------------------------------------------
`include "point_segment_distance_top_macros.svh"

module point_segment_distance_top #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_start_x,
    input  logic [COORD_WIDTH-1:0] i_start_y,
    input  logic [COORD_WIDTH-1:0] i_end_x,
    input  logic [COORD_WIDTH-1:0] i_end_y,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_WIDTH:0]   o_distance
);

    localparam int W    = COORD_WIDTH;
    localparam int DIFW = W + 1;          // coordinate difference
    localparam int PRW  = 2 * DIFW;       // signed product
    localparam int LENW = 2 * W + 2;      // squared length
    localparam int DOTW = 2 * W + 3;      // signed dot / cross
    localparam int CRW  = 2 * W + 2;      // cross magnitude
    localparam int QW   = 2 * W + 1;      // squared distance
    localparam int H    = (CRW + 1) / 2;  // low half of cross magnitude
    localparam int HW   = CRW - H;        // high half
    localparam int NUMW = 2 * CRW;        // squared cross
    localparam int RW   = W + 1;          // distance

    // global advance: output stage empty or being taken
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // ---------------- stage 1: differences ----------------
    logic                   r1_vld;
    logic signed [DIFW-1:0] r1_ux, r1_uy, r1_dx, r1_dy, r1_vx, r1_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ux <= {i_point_x[W-1], i_point_x} - {i_start_x[W-1], i_start_x};
            r1_uy <= {i_point_y[W-1], i_point_y} - {i_start_y[W-1], i_start_y};
            r1_dx <= {i_end_x[W-1], i_end_x} - {i_start_x[W-1], i_start_x};
            r1_dy <= {i_end_y[W-1], i_end_y} - {i_start_y[W-1], i_start_y};
            r1_vx <= {i_point_x[W-1], i_point_x} - {i_end_x[W-1], i_end_x};
            r1_vy <= {i_point_y[W-1], i_point_y} - {i_end_y[W-1], i_end_y};
        end
    end

    // ---------------- stage 2: products ----------------
    logic                  r2_vld;
    logic signed [PRW-1:0] r2_uxdx, r2_uydy, r2_uxdy, r2_uydx;
    logic signed [PRW-1:0] r2_dxdx, r2_dydy, r2_uxux, r2_uyuy, r2_vxvx, r2_vyvy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_uxdx <= PRW'(r1_ux) * PRW'(r1_dx);
            r2_uydy <= PRW'(r1_uy) * PRW'(r1_dy);
            r2_uxdy <= PRW'(r1_ux) * PRW'(r1_dy);
            r2_uydx <= PRW'(r1_uy) * PRW'(r1_dx);
            r2_dxdx <= PRW'(r1_dx) * PRW'(r1_dx);
            r2_dydy <= PRW'(r1_dy) * PRW'(r1_dy);
            r2_uxux <= PRW'(r1_ux) * PRW'(r1_ux);
            r2_uyuy <= PRW'(r1_uy) * PRW'(r1_uy);
            r2_vxvx <= PRW'(r1_vx) * PRW'(r1_vx);
            r2_vyvy <= PRW'(r1_vy) * PRW'(r1_vy);
        end
    end

    // ---------------- stage 3: sums ----------------
    logic                   r3_vld;
    logic [LENW-1:0]        r3_len2, r3_su, r3_sv;
    logic signed [DOTW-1:0] r3_dot, r3_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_len2  <= r2_dxdx[LENW-1:0] + r2_dydy[LENW-1:0];
            r3_su    <= r2_uxux[LENW-1:0] + r2_uyuy[LENW-1:0];
            r3_sv    <= r2_vxvx[LENW-1:0] + r2_vyvy[LENW-1:0];
            r3_dot   <= DOTW'(r2_uxdx) + DOTW'(r2_uydy);
            r3_cross <= DOTW'(r2_uxdy) - DOTW'(r2_uydx);
        end
    end

    // ---------------- stage 4: path select ----------------
    logic            r4_vld;
    logic            r4_perp;
    logic [QW-1:0]   r4_ep;
    logic [CRW-1:0]  r4_crm;
    logic [LENW-1:0] r4_len2;
    logic            n4_perp;
    logic [QW-1:0]   n4_ep;
    logic [DOTW-1:0] n4_abs;

    always_comb begin
        n4_perp = 1'b0;
        n4_ep   = r3_su[QW-1:0];
        // degenerate segment or before the start: distance to start
        priority if ((r3_len2 == '0) || r3_dot[DOTW-1]) begin
            n4_ep = r3_su[QW-1:0];
        end else if (r3_dot[LENW-1:0] > r3_len2) begin
            n4_ep = r3_sv[QW-1:0];
        end else begin
            n4_perp = 1'b1;
        end
        n4_abs = r3_cross[DOTW-1] ? DOTW'(-r3_cross) : DOTW'(r3_cross);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_perp <= n4_perp;
            r4_ep   <= n4_ep;
            r4_crm  <= n4_abs[CRW-1:0];
            r4_len2 <= r3_len2;
        end
    end

    // ---------------- stage 5: cross squared, partial products ----------------
    logic              r5_vld;
    logic              r5_perp;
    logic [QW-1:0]     r5_ep;
    logic [LENW-1:0]   r5_len2;
    logic [2*H-1:0]    r5_ll;
    logic [H+HW-1:0]   r5_lh;
    logic [2*HW-1:0]   r5_hh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_perp <= r4_perp;
            r5_ep   <= r4_ep;
            r5_len2 <= r4_len2;
            r5_ll   <= (2*H)'(r4_crm[H-1:0]) * (2*H)'(r4_crm[H-1:0]);
            r5_lh   <= (H+HW)'(r4_crm[H-1:0]) * (H+HW)'(r4_crm[CRW-1:H]);
            r5_hh   <= (2*HW)'(r4_crm[CRW-1:H]) * (2*HW)'(r4_crm[CRW-1:H]);
        end
    end

    // ---------------- stage 6: numerator and divisor ----------------
    logic            r6_vld;
    logic [NUMW-1:0] r6_num;
    logic [LENW-1:0] r6_den;
    logic [NUMW-1:0] n6_sq;

    assign n6_sq = {r5_hh, r5_ll} + (NUMW'(r5_lh) << (H + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_num <= r5_perp ? n6_sq : NUMW'(r5_ep);
            r6_den <= r5_perp ? r5_len2 : LENW'(1);
        end
    end

    // ---------------- divider and square root ----------------
    logic            w_div_vld;
    logic [QW-1:0]   w_quo;

    psd_div #(
        .NUMW (NUMW),
        .DENW (LENW),
        .QW   (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_vld),
        .i_num   (r6_num),
        .i_den   (r6_den),
        .o_valid (w_div_vld),
        .o_quo   (w_quo)
    );

    psd_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_vld),
        .i_rad   ((2*RW)'(w_quo)),
        .o_valid (o_valid),
        .o_root  (o_distance)
    );

    // ---------------- assertions ----------------
    // degenerate segment never takes the projection path
    `PSD_ASSERT_NXT(a_degen_to_start, i_clk, i_rst_n, w_en && r3_vld && (r3_len2 == '0), !r4_perp)
    // endpoint distances go through the divider with a unit divisor
    `PSD_ASSERT_NXT(a_endpoint_unit_den, i_clk, i_rst_n, w_en && r5_vld && !r5_perp, r6_den == LENW'(1))
    // a stalled pipeline keeps the valid bits of its first and sixth stages
    `PSD_ASSERT_NXT(a_stall_holds_front, i_clk, i_rst_n, !w_en, $stable(r1_vld) && $stable(r6_vld))

endmodule
